[hdl/newton_nth_root_assert.svh]
// ----------------------------------------------------------------------------
// newton_nth_root assertion macros
// Shorthand for clocked implication checks used at the top level.
// ----------------------------------------------------------------------------
`ifndef NEWTON_NTH_ROOT_ASSERT_SVH
`define NEWTON_NTH_ROOT_ASSERT_SVH

// same-cycle implication
`define NNR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define NNR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hdl/nnr_pkg.sv]
// ----------------------------------------------------------------------------
// nnr_pkg
// Types and constants shared by the Newton n-th root controller and datapath.
// ----------------------------------------------------------------------------
package nnr_pkg;

    localparam int DATA_W = 32;
    localparam int DEG_W  = 6;
    localparam int MAG_W  = 63;
    localparam int DIV_DVS_W = 64;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_DEG_LOW  = 3'd1;
    localparam logic [2:0] STATUS_NEG_EVEN = 3'd2;
    localparam logic [2:0] STATUS_ITER_CAP = 3'd3;
    localparam logic [2:0] STATUS_ZERO_DIV = 3'd4;

    localparam logic [1:0] DSEL_T1  = 2'd0;
    localparam logic [1:0] DSEL_T2  = 2'd1;
    localparam logic [1:0] DSEL_ERR = 2'd2;

    typedef struct packed {
        logic       load;
        logic       pow_init;
        logic       mul_a;
        logic       mul_b;
        logic       store_pmn;
        logic       div_load;
        logic [1:0] div_sel;
        logic       div_step;
        logic       store_t1;
        logic       store_t2;
        logic       clear_t2;
        logic       update_r;
        logic       store_diff;
        logic       store_err;
        logic       finish;
        logic       fin_zero;
        logic [2:0] fin_status;
    } nnr_cmd_t;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic             s_neg;
        logic             s_zero;
        logic             p_zero;
        logic             pmn_ovf;
        logic             converged;
    } nnr_stat_t;

endpackage

[hdl/nnr_datapath.sv]
// ----------------------------------------------------------------------------
// nnr_datapath
// Operand registers, split power multiplier, shared restoring divider and
// result registers for the Newton n-th root.
// ----------------------------------------------------------------------------
module nnr_datapath
    import nnr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [DATA_W-1:0]        cfg_wdata,
    input  logic signed [DATA_W-1:0] value,
    input  logic [DEG_W-1:0]         degree,
    input  nnr_cmd_t                 cmd,
    output nnr_stat_t                stat,
    output logic signed [DATA_W-1:0] root,
    output logic [DATA_W-1:0]        rel_error,
    output logic [2:0]               status
);

    localparam int DW = DIV_DVS_W + FRAC_BITS;
    localparam int PMN_W = MAG_W + DEG_W;

    logic [DATA_W-1:0]        precision_reg;
    logic [DATA_W-1:0]        s_mag_reg;
    logic                     s_neg_reg;
    logic [DEG_W-1:0]         n_reg;
    logic signed [DATA_W-1:0] r_reg;
    logic [MAG_W-1:0]         p_reg;
    logic [63:0]              plo_reg;
    logic [PMN_W-1:0]         pmn_reg;
    logic signed [63:0]       t1_reg;
    logic [63:0]              t2_reg;
    logic [63:0]              diff_reg;
    logic [DATA_W-1:0]        err_reg;
    logic [63:0]              rem_reg;
    logic [DW-1:0]            dvd_reg;
    logic [63:0]              dvs_reg;
    logic signed [DATA_W-1:0] root_reg;
    logic [DATA_W-1:0]        rel_error_reg;
    logic [2:0]               status_reg;

    logic                     r_neg;
    logic [DATA_W-1:0]        r_mag;
    logic [DATA_W-1:0]        v_mag;
    logic [63:0]              plo_next;
    logic [62:0]              phi;
    logic [94:0]              full;
    logic [94:0]              shifted;
    logic [MAG_W-1:0]         p_next;
    logic [37:0]              t1_num;
    logic [DW-1:0]            dvd_init;
    logic [63:0]              dvs_init;
    logic [64:0]              rem_sh;
    logic                     ge;
    logic [64:0]              rem_sub;
    logic signed [63:0]       q_signed;
    logic                     p_neg;
    logic signed [63:0]       nr;
    logic signed [DATA_W-1:0] r_next;
    logic                     d_neg;
    logic [63:0]              diff_next;
    logic [DATA_W-1:0]        err_next;

    always_comb
    begin
        r_neg    = r_reg[DATA_W-1];
        r_mag    = r_neg ? (DATA_W'(0) - DATA_W'(r_reg)) : DATA_W'(r_reg);
        v_mag    = value[DATA_W-1] ? (DATA_W'(0) - DATA_W'(value)) : DATA_W'(value);
        plo_next = 64'(p_reg[31:0]) * 64'(r_mag);
        phi      = 63'(p_reg[62:32]) * 63'(r_mag);
        full     = {phi[62:0], 32'd0} + 95'(plo_reg);
        shifted  = full >> FRAC_BITS;
        p_next   = (shifted[94:MAG_W] != '0) ? MAG_MAX : shifted[MAG_W-1:0];
        t1_num   = 38'(n_reg - 6'd1) * 38'(r_mag);

        dvd_init = DW'(t1_num);
        dvs_init = 64'(n_reg);
        case (cmd.div_sel)
            DSEL_T2:
            begin
                dvd_init = DW'(s_mag_reg) << FRAC_BITS;
                dvs_init = pmn_reg[63:0];
            end
            DSEL_ERR:
            begin
                dvd_init = {diff_reg, {FRAC_BITS{1'b0}}};
                dvs_init = 64'(s_mag_reg);
            end
            default:
            begin
                dvd_init = DW'(t1_num);
                dvs_init = 64'(n_reg);
            end
        endcase

        rem_sh  = {rem_reg, dvd_reg[DW-1]};
        ge      = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};

        q_signed = r_neg ? (64'sd0 - $signed(dvd_reg[63:0])) : $signed(dvd_reg[63:0]);

        p_neg = r_neg & ~n_reg[0];
        nr    = (s_neg_reg != p_neg) ? (t1_reg - $signed(t2_reg)) : (t1_reg + $signed(t2_reg));
        if (nr > 64'sh7FFFFFFF)
            r_next = 32'sh7FFFFFFF;
        else if (nr < -64'sh80000000)
            r_next = 32'sh80000000;
        else
            r_next = nr[DATA_W-1:0];

        d_neg = r_neg & n_reg[0] & (p_reg != '0);
        if (d_neg == s_neg_reg)
            diff_next = (64'(s_mag_reg) > 64'(p_reg)) ? (64'(s_mag_reg) - 64'(p_reg))
                                                      : (64'(p_reg) - 64'(s_mag_reg));
        else
            diff_next = 64'(s_mag_reg) + 64'(p_reg);

        err_next = (dvd_reg[DW-1:DATA_W] != '0) ? {DATA_W{1'b1}} : dvd_reg[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            precision_reg <= DATA_W'(66);
        else if (cfg_we)
            precision_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_mag_reg <= v_mag;
            s_neg_reg <= value[DATA_W-1];
            n_reg     <= degree;
            r_reg     <= DATA_W'(1) << FRAC_BITS;
        end
        if (cmd.pow_init)
            p_reg <= MAG_W'(1) << FRAC_BITS;
        if (cmd.mul_a)
            plo_reg <= plo_next;
        if (cmd.mul_b)
            p_reg <= p_next;
        if (cmd.store_pmn)
            pmn_reg <= PMN_W'(p_reg) * PMN_W'(n_reg);
        if (cmd.div_load)
        begin
            rem_reg <= '0;
            dvd_reg <= dvd_init;
            dvs_reg <= dvs_init;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? rem_sub[63:0] : rem_sh[63:0];
            dvd_reg <= {dvd_reg[DW-2:0], ge};
        end
        if (cmd.store_t1)
            t1_reg <= q_signed;
        if (cmd.store_t2)
            t2_reg <= dvd_reg[63:0];
        else if (cmd.clear_t2)
            t2_reg <= '0;
        if (cmd.update_r)
            r_reg <= r_next;
        if (cmd.store_diff)
            diff_reg <= diff_next;
        if (cmd.store_err)
            err_reg <= err_next;
        if (cmd.finish)
        begin
            root_reg      <= cmd.fin_zero ? '0 : r_reg;
            rel_error_reg <= cmd.fin_zero ? '0 : err_reg;
            status_reg    <= cmd.fin_status;
        end
    end

    assign stat.degree    = n_reg;
    assign stat.s_neg     = s_neg_reg;
    assign stat.s_zero    = (s_mag_reg == '0);
    assign stat.p_zero    = (p_reg == '0);
    assign stat.pmn_ovf   = (pmn_reg[PMN_W-1:MAG_W] != '0);
    assign stat.converged = (err_reg <= precision_reg);

    assign root      = root_reg;
    assign rel_error = rel_error_reg;
    assign status    = status_reg;

endmodule

[hdl/nnr_controller.sv]
// ----------------------------------------------------------------------------
// nnr_controller
// Sequencer for the Newton passes: power loops, divisions, update, stop test.
// ----------------------------------------------------------------------------
module nnr_controller
    import nnr_pkg::*;
#(
    parameter int FRAC_BITS      = 16,
    parameter int MAX_ITERATIONS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  nnr_stat_t stat,
    output nnr_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    localparam int DW  = DIV_DVS_W + FRAC_BITS;
    localparam int DCW = $clog2(DW);
    localparam int IW  = $clog2(MAX_ITERATIONS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_PINIT  = 4'd2;
    localparam logic [3:0] S_MA     = 4'd3;
    localparam logic [3:0] S_MB     = 4'd4;
    localparam logic [3:0] S_PM     = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_T2S    = 4'd7;
    localparam logic [3:0] S_T2E    = 4'd8;
    localparam logic [3:0] S_UPD    = 4'd9;
    localparam logic [3:0] S_DIFF   = 4'd10;
    localparam logic [3:0] S_ELOAD  = 4'd11;
    localparam logic [3:0] S_ERRCHK = 4'd12;
    localparam logic [3:0] S_CONV   = 4'd13;

    logic [3:0]       state_reg, state_next;
    logic [DEG_W-1:0] mul_cnt_reg, mul_cnt_next;
    logic [DCW-1:0]   div_cnt_reg, div_cnt_next;
    logic [IW-1:0]    iter_reg, iter_next;
    logic             pw_sel_reg, pw_sel_next;
    logic [1:0]       dsel_reg, dsel_next;
    logic             done_reg, done_next;
    logic [DEG_W:0]   pow_target;
    logic             mul_last;

    always_comb
    begin
        pow_target = pw_sel_reg ? {1'b0, stat.degree} : ({1'b0, stat.degree} - 7'd1);
        mul_last   = ({1'b0, mul_cnt_reg} + 7'd1) == pow_target;

        state_next   = state_reg;
        mul_cnt_next = mul_cnt_reg;
        div_cnt_next = div_cnt_reg;
        iter_next    = iter_reg;
        pw_sel_next  = pw_sel_reg;
        dsel_next    = dsel_reg;
        done_next    = 1'b0;
        cmd          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                iter_next   = '0;
                pw_sel_next = 1'b0;
                if (stat.degree < DEG_W'(2))
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_zero   = 1'b1;
                    cmd.fin_status = STATUS_DEG_LOW;
                end
                else if (stat.s_neg && !stat.degree[0])
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_zero   = 1'b1;
                    cmd.fin_status = STATUS_NEG_EVEN;
                end
                else if (stat.s_zero)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_zero   = 1'b1;
                    cmd.fin_status = STATUS_OK;
                end
                if (cmd.finish)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_PINIT;
            end
            S_PINIT:
            begin
                cmd.pow_init = 1'b1;
                mul_cnt_next = '0;
                state_next   = S_MA;
            end
            S_MA:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MB;
            end
            S_MB:
            begin
                cmd.mul_b    = 1'b1;
                mul_cnt_next = mul_cnt_reg + DEG_W'(1);
                if (mul_last)
                    state_next = pw_sel_reg ? S_DIFF : S_PM;
                else
                    state_next = S_MA;
            end
            S_PM:
            begin
                if (stat.p_zero)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_zero   = 1'b1;
                    cmd.fin_status = STATUS_ZERO_DIV;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.store_pmn = 1'b1;
                    cmd.div_load  = 1'b1;
                    cmd.div_sel   = DSEL_T1;
                    dsel_next     = DSEL_T1;
                    div_cnt_next  = '0;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(DW - 1))
                begin
                    unique case (dsel_reg)
                        DSEL_T1:  state_next = S_T2S;
                        DSEL_T2:  state_next = S_T2E;
                        default:  state_next = S_ERRCHK;
                    endcase
                end
            end
            S_T2S:
            begin
                cmd.store_t1 = 1'b1;
                if (stat.pmn_ovf)
                begin
                    cmd.clear_t2 = 1'b1;
                    state_next   = S_UPD;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_sel  = DSEL_T2;
                    dsel_next    = DSEL_T2;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_T2E:
            begin
                cmd.store_t2 = 1'b1;
                state_next   = S_UPD;
            end
            S_UPD:
            begin
                cmd.update_r = 1'b1;
                pw_sel_next  = 1'b1;
                state_next   = S_PINIT;
            end
            S_DIFF:
            begin
                cmd.store_diff = 1'b1;
                state_next     = S_ELOAD;
            end
            S_ELOAD:
            begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = DSEL_ERR;
                dsel_next    = DSEL_ERR;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_ERRCHK:
            begin
                cmd.store_err = 1'b1;
                state_next    = S_CONV;
            end
            S_CONV:
            begin
                if (stat.converged || iter_reg == IW'(MAX_ITERATIONS - 1))
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = stat.converged ? STATUS_OK : STATUS_ITER_CAP;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    iter_next   = iter_reg + IW'(1);
                    pw_sel_next = 1'b0;
                    state_next  = S_PINIT;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mul_cnt_reg <= '0;
            div_cnt_reg <= '0;
            iter_reg    <= '0;
            pw_sel_reg  <= 1'b0;
            dsel_reg    <= DSEL_T1;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mul_cnt_reg <= mul_cnt_next;
            div_cnt_reg <= div_cnt_next;
            iter_reg    <= iter_next;
            pw_sel_reg  <= pw_sel_next;
            dsel_reg    <= dsel_next;
            done_reg    <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

[hdl/newton_nth_root.sv]
// ----------------------------------------------------------------------------
// newton_nth_root
// Signed Q16.16 n-th root by Newton iteration, guess starting at one.
// For degree below two, negative-even or zero input, done is registered from
// the check state after acceptance. Otherwise each pass runs power loops on
// a multiply split over the MA and MB states and up to three divisions at one
// quotient bit per cycle (the second is skipped when n*R^(n-1) overflows); up
// to MAX_ITERATIONS passes. One transaction at a time, busy while working.
// Reset: precision returns to 66, controller idles, done stays low.
// ----------------------------------------------------------------------------
`include "newton_nth_root_assert.svh"

module newton_nth_root
    import nnr_pkg::*;
#(
    parameter int FRAC_BITS      = 16,
    parameter int MAX_ITERATIONS = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] value,
    input  logic [DEG_W-1:0]         degree,
    input  logic                     cfg_we,
    input  logic [DATA_W-1:0]        cfg_wdata,
    output logic                     done,
    output logic signed [DATA_W-1:0] root,
    output logic [DATA_W-1:0]        rel_error,
    output logic [2:0]               status
);

    nnr_cmd_t  cmd;
    nnr_stat_t stat;
    logic      fail_code;

    nnr_controller #(
        .FRAC_BITS      (FRAC_BITS),
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    nnr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .value     (value),
        .degree    (degree),
        .cmd       (cmd),
        .stat      (stat),
        .root      (root),
        .rel_error (rel_error),
        .status    (status)
    );

    assign fail_code = (status == STATUS_DEG_LOW) || (status == STATUS_NEG_EVEN) ||
                       (status == STATUS_ZERO_DIV);

    `NNR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `NNR_ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)
    `NNR_ASSERT_IMPLY(a_err_zero, clk, rst_n, done && fail_code, root == '0 && rel_error == '0)

endmodule

[sim/newton_nth_root_tb.sv]
// ----------------------------------------------------------------------------
// newton_nth_root_tb
// Self-checking bench for the Newton n-th root block. A directed table walks
// the degree checks, zero and full-scale values, then random values run under
// several precision settings. Each result is checked against its typed row or
// a predictor mirroring the fixed-point Newton iteration, random start idling.
// ----------------------------------------------------------------------------
module newton_nth_root_tb;
    import nnr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int PASSES = 64;
    localparam longint unsigned CYCLE_LIMIT = 100_000_000;
    localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [DATA_W-1:0] root;
        logic [DATA_W-1:0]        rel_error;
        logic [2:0]               status;
    } root_result_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [DEG_W-1:0]         degree;
        bit                       typed;
        root_result_t             want;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] value;
    logic [DEG_W-1:0]         degree;
    logic                     cfg_we;
    logic [DATA_W-1:0]        cfg_wdata;
    logic                     done;
    logic signed [DATA_W-1:0] root;
    logic [DATA_W-1:0]        rel_error;
    logic [2:0]               status;

    root_result_t   pending_roots[$];
    logic [31:0]    precision_q;
    int             mismatches = 0;
    longint unsigned cycles = 0;
    bit             quiet_phase = 1'b0;

    newton_nth_root uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .degree    (degree),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .root      (root),
        .rel_error (rel_error),
        .status    (status)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        p = p >> FRAC;
        if (p > 128'(MAG_LIMIT))
            return MAG_LIMIT;
        return p[63:0];
    endfunction

    function automatic logic [63:0] fx_pow(logic [63:0] mag, int k);
        logic [63:0] acc;
        acc = 64'd1 << FRAC;
        for (int i = 0; i < k; i++)
            acc = fx_mul(acc, mag);
        return acc;
    endfunction

    function automatic root_result_t nth_root_predict(logic signed [31:0] v,
                                                      logic [5:0] d);
        root_result_t res;
        longint signed s, r, t1, nr;
        longint unsigned smag, rmag, pm, t2, dm, diff, q, err;
        longint signed n;
        bit sneg, rneg, pneg, dneg;
        res.root = '0;
        res.rel_error = '0;
        res.status = STATUS_ITER_CAP;
        s = longint'(v);
        n = longint'(d);
        sneg = s < 0;
        smag = sneg ? -s : s;
        r = 64'sd1 <<< FRAC;
        err = 0;
        if (n < 2) begin
            res.status = STATUS_DEG_LOW;
            return res;
        end
        if (sneg && n % 2 == 0) begin
            res.status = STATUS_NEG_EVEN;
            return res;
        end
        if (s == 0) begin
            res.status = STATUS_OK;
            return res;
        end
        for (int it = 0; it < PASSES; it++) begin
            rneg = r < 0;
            rmag = rneg ? -r : r;
            pm = fx_pow(rmag, int'(n) - 1);
            pneg = rneg && ((n - 1) % 2 == 1);
            if (pm == 0) begin
                res.status = STATUS_ZERO_DIV;
                return res;
            end
            t1 = ((n - 1) * r) / n;
            t2 = 0;
            if (pm <= MAG_LIMIT / longint'(n))
                t2 = (smag << FRAC) / (pm * longint'(n));
            nr = (sneg != pneg) ? t1 - longint'(t2) : t1 + longint'(t2);
            if (nr > 64'sd2147483647)
                nr = 64'sd2147483647;
            if (nr < -64'sd2147483648)
                nr = -64'sd2147483648;
            r = nr;
            rneg = r < 0;
            rmag = rneg ? -r : r;
            dm = fx_pow(rmag, int'(n));
            dneg = rneg && (n % 2 == 1);
            if (dm == 0)
                dneg = 1'b0;
            if (dneg == sneg)
                diff = (smag > dm) ? smag - dm : dm - smag;
            else
                diff = smag + dm;
            q = diff / smag;
            if (q >= (64'd1 << (32 - FRAC)))
                err = 64'hFFFF_FFFF;
            else
                err = (q << FRAC) + (((diff % smag) << FRAC) / smag);
            if (err <= precision_q) begin
                res.status = STATUS_OK;
                break;
            end
        end
        res.root = r[31:0];
        res.rel_error = err[31:0];
        return res;
    endfunction

    task automatic send_transaction(logic signed [31:0] v, logic [5:0] d,
                                    bit typed, root_result_t want);
        if (!quiet_phase && $urandom_range(99) < 11) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start  <= 1'b1;
        value  <= v;
        degree <= d;
        do
            @(posedge clk);
        while (busy);
        pending_roots.push_back(typed ? want : nth_root_predict(v, d));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_precision(logic [31:0] p);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we    <= 1'b0;
        precision_q = p;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(32'h0001_0000, 1);
            2: return $urandom_range(32'h0100_0000, 32'h0001_0000);
            3: return -$signed($urandom_range(32'h0010_0000, 1));
            4: return $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
            default: return $urandom_range(32'h0064_0000, 32'h0000_4000);
        endcase
    endfunction

    function automatic logic [5:0] pick_degree(bit small_only);
        int k;
        k = $urandom_range(99);
        if (small_only || k < 80)
            return 6'($urandom_range(5, 2));
        if (k < 88)
            return 6'($urandom_range(1, 0));
        return 6'($urandom_range(63, 6));
    endfunction

    task automatic random_phase(int count, bit small_only);
        root_result_t none;
        none = '{default: '0};
        for (int i = 0; i < count; i++)
            send_transaction(pick_value(), pick_degree(small_only), 1'b0, none);
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("newton_nth_root verification failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        root_result_t exp_r;
        if (rst_n && done) begin
            if (pending_roots.size() == 0) begin
                $display("%0t unexpected result root=%h rel_error=%h status=%0d",
                         $time, root, rel_error, status);
                mismatches++;
            end else begin
                exp_r = pending_roots.pop_front();
                if (root !== exp_r.root) begin
                    $display("%0t root expected %h actual %h", $time, exp_r.root, root);
                    mismatches++;
                end
                if (rel_error !== exp_r.rel_error) begin
                    $display("%0t rel_error expected %h actual %h",
                             $time, exp_r.rel_error, rel_error);
                    mismatches++;
                end
                if (status !== exp_r.status) begin
                    $display("%0t status expected %0d actual %0d",
                             $time, exp_r.status, status);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        stim_row_t table_rows[$];
        root_result_t z;
        z = '{default: '0};
        rst_n     <= 1'b0;
        start     <= 1'b0;
        value     <= '0;
        degree    <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        precision_q = 32'd66;
        table_rows = '{
            '{32'sh0004_0000, 6'd0,  1'b1, '{32'sd0, 32'd0, STATUS_DEG_LOW}},
            '{32'sh7FFF_FFFF, 6'd1,  1'b1, '{32'sd0, 32'd0, STATUS_DEG_LOW}},
            '{-32'sh8000_0000, 6'd1, 1'b1, '{32'sd0, 32'd0, STATUS_DEG_LOW}},
            '{-32'sh8000_0000, 6'd2, 1'b1, '{32'sd0, 32'd0, STATUS_NEG_EVEN}},
            '{-32'sd1, 6'd62,        1'b1, '{32'sd0, 32'd0, STATUS_NEG_EVEN}},
            '{32'sd0, 6'd2,          1'b1, '{32'sd0, 32'd0, STATUS_OK}},
            '{32'sd0, 6'd63,         1'b1, '{32'sd0, 32'd0, STATUS_OK}},
            '{32'sd0, 6'd0,          1'b1, '{32'sd0, 32'd0, STATUS_DEG_LOW}},
            '{32'sh0004_0000, 6'd2,  1'b0, z},
            '{32'sh0001_0000, 6'd3,  1'b0, z},
            '{32'sh7FFF_FFFF, 6'd2,  1'b0, z},
            '{-32'sh8000_0000, 6'd3, 1'b0, z},
            '{-32'sh0008_0000, 6'd3, 1'b0, z},
            '{32'sd1, 6'd2,          1'b0, z},
            '{32'sd1, 6'd9,          1'b0, z},
            '{32'sd1, 6'd63,         1'b0, z},
            '{32'sh0002_0000, 6'd63, 1'b0, z},
            '{-32'sd1, 6'd63,        1'b0, z},
            '{32'sh5555_5555, 6'd5,  1'b0, z},
            '{32'sh2AAA_AAAA, 6'd42, 1'b0, z}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_rows[i])
            send_transaction(table_rows[i].value, table_rows[i].degree,
                             table_rows[i].typed, table_rows[i].want);
        random_phase(200, 1'b0);
        write_precision(32'hFFFF_FFFF);
        quiet_phase = 1'b1;
        random_phase(80, 1'b0);
        quiet_phase = 1'b0;
        write_precision(32'd0);
        random_phase(30, 1'b1);
        write_precision(32'd655);
        random_phase(150, 1'b0);
        write_precision($urandom_range(32'h0000_2000, 32'd1));
        random_phase(140, 1'b0);
        drain_results();
        if (mismatches == 0)
            $display("newton_nth_root verification clean");
        else
            $display("newton_nth_root verification failed");
        $finish;
    end
endmodule
